// ===== rtl/core/rtlhc_pkg.sv =====
// ============================================================================
// rtlhc_pkg: shared definitions for the route table with last-hit cache
// Table geometry, field widths, operation and status codes, and the
// controller state type.
// ============================================================================
package rtlhc_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W      = 32;
    localparam int IFC_W       = 16;
    localparam int ENTRY_W     = ADDR_W + IFC_W;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEARCH,
        ST_SHIFT,
        ST_REPLY
    } state_t;

endpackage

// ===== rtl/core/rtlhc_ram.sv =====
// ============================================================================
// rtlhc_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ============================================================================
module rtlhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/route_table_last_hit_cache_top.sv =====
// ============================================================================
// route_table_last_hit_cache_top: exact-match route table with last-hit cache
// Insertion-ordered (address, interface) table in one RAM, a one-entry cache
// of the last successful table lookup, and a sequencer for lookup, insert and
// delete.
// ============================================================================
// The block takes one transaction at a time and returns exactly one result
// transaction for each. A lookup that hits the cache, an insert and an unused
// mode go from idle through dispatch to reply. A lookup that misses the cache
// walks the table from the newest entry to the oldest through the table RAM,
// one read issued per cycle, with the read data registered in the RAM; it
// examines entry_count entries when nothing matches. A delete walks the same
// way, and a delete that finds nothing costs the same as a lookup miss. When
// it finds the address at position p, it then moves the entries above p down
// one place, one RAM read and one write per cycle. The worst case is deleting
// the oldest entry of a full table of 64. The single read port of the table
// RAM limits these walks. A new transaction is accepted as soon as the
// sequencer is back in idle, even while the previous result still waits on
// the output register; a finished result that finds the output register
// still occupied waits, and the block with it, until that register empties.
module route_table_last_hit_cache_top (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_mode,
    input  logic [rtlhc_pkg::ADDR_W-1:0] s_route_address,
    input  logic [rtlhc_pkg::IFC_W-1:0]  s_route_interface,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [rtlhc_pkg::IFC_W-1:0]  m_found_interface,
    output logic                       m_from_cache
);

    import rtlhc_pkg::*;

    // Sequencer state and the latched request.
    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [IFC_W-1:0]    ifc_reg, ifc_next;

    // Table fill level and the last-hit cache.
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                cache_valid_reg, cache_valid_next;
    logic [ADDR_W-1:0]   cache_addr_reg, cache_addr_next;
    logic [IFC_W-1:0]    cache_ifc_reg, cache_ifc_next;

    // Walk pointers. During a search ptr_reg counts the entries not yet
    // issued to the RAM; during a shift it is the next entry to read.
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]    wr_idx_reg, wr_idx_next;
    logic                shift_vld_reg, shift_vld_next;

    // Finished result waiting for the output register.
    status_t             res_status_reg, res_status_next;
    logic [IFC_W-1:0]    res_ifc_reg, res_ifc_next;
    logic                res_cache_reg, res_cache_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [IFC_W-1:0]    m_found_reg, m_found_next;
    logic                m_cache_reg, m_cache_next;

    // Table RAM ports.
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;
    logic [ENTRY_W-1:0]  mem_rdata;

    logic [ADDR_W-1:0]   rd_addr;
    logic [IFC_W-1:0]    rd_ifc;
    logic [CNT_W-1:0]    ptr_dec;
    logic                match;
    logic                cache_hit;

    rtlhc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_addr   = mem_rdata[ENTRY_W-1:IFC_W];
    assign rd_ifc    = mem_rdata[IFC_W-1:0];
    assign ptr_dec   = ptr_reg - CNT_W'(1);
    assign match     = cmp_vld_reg && (rd_addr == addr_reg);
    assign cache_hit = cache_valid_reg && (cache_addr_reg == addr_reg);

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_found_interface = m_found_reg;
    assign m_from_cache      = m_cache_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            cache_valid_reg <= 1'b0;
            cache_addr_reg  <= '0;
            cache_ifc_reg   <= '0;
            cmp_vld_reg     <= 1'b0;
            shift_vld_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            cache_valid_reg <= cache_valid_next;
            cache_addr_reg  <= cache_addr_next;
            cache_ifc_reg   <= cache_ifc_next;
            cmp_vld_reg     <= cmp_vld_next;
            shift_vld_reg   <= shift_vld_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        addr_reg       <= addr_next;
        ifc_reg        <= ifc_next;
        ptr_reg        <= ptr_next;
        cmp_idx_reg    <= cmp_idx_next;
        wr_idx_reg     <= wr_idx_next;
        res_status_reg <= res_status_next;
        res_ifc_reg    <= res_ifc_next;
        res_cache_reg  <= res_cache_next;
        m_status_reg   <= m_status_next;
        m_found_reg    <= m_found_next;
        m_cache_reg    <= m_cache_next;
    end

    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        addr_next        = addr_reg;
        ifc_next         = ifc_reg;
        count_next       = count_reg;
        cache_valid_next = cache_valid_reg;
        cache_addr_next  = cache_addr_reg;
        cache_ifc_next   = cache_ifc_reg;
        ptr_next         = ptr_reg;
        cmp_vld_next     = cmp_vld_reg;
        cmp_idx_next     = cmp_idx_reg;
        wr_idx_next      = wr_idx_reg;
        shift_vld_next   = shift_vld_reg;
        res_status_next  = res_status_reg;
        res_ifc_next     = res_ifc_reg;
        res_cache_next   = res_cache_reg;
        m_status_next    = m_status_reg;
        m_found_next     = m_found_reg;
        m_cache_next     = m_cache_reg;

        // The output slot empties when its transaction is taken.
        m_valid_next     = m_valid_reg && !m_ready;

        mem_we    = 1'b0;
        mem_waddr = wr_idx_reg;
        mem_wdata = {addr_reg, ifc_reg};
        mem_raddr = ptr_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next  = mode_t'(s_mode);
                    addr_next  = s_route_address;
                    ifc_next   = s_route_interface;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH: begin
                res_status_next = STATUS_MISS;
                res_ifc_next    = '0;
                res_cache_next  = 1'b0;
                ptr_next        = count_reg;
                cmp_vld_next    = 1'b0;
                state_next      = ST_REPLY;
                case (mode_reg)
                    MODE_LOOKUP: begin
                        if (cache_hit) begin
                            res_status_next = STATUS_OK;
                            res_ifc_next    = cache_ifc_reg;
                            res_cache_next  = 1'b1;
                        end else begin
                            state_next = ST_SEARCH;
                        end
                    end
                    MODE_INSERT: begin
                        if (count_reg >= CNT_W'(TABLE_DEPTH)) begin
                            res_status_next = STATUS_FULL;
                        end else begin
                            mem_we          = 1'b1;
                            mem_waddr       = count_reg[IDX_W-1:0];
                            count_next      = count_reg + CNT_W'(1);
                            res_status_next = STATUS_OK;
                        end
                    end
                    MODE_DELETE: begin
                        state_next = ST_SEARCH;
                    end
                    default: begin
                        // Unused mode: reported as a miss, state untouched.
                    end
                endcase
            end

            ST_SEARCH: begin
                // Reads are issued newest first; each cycle compares the
                // entry whose data came back from the previous read.
                if (match) begin
                    cmp_vld_next = 1'b0;
                    if (mode_reg == MODE_LOOKUP) begin
                        res_status_next  = STATUS_OK;
                        res_ifc_next     = rd_ifc;
                        res_cache_next   = 1'b0;
                        cache_valid_next = 1'b1;
                        cache_addr_next  = addr_reg;
                        cache_ifc_next   = rd_ifc;
                        state_next       = ST_REPLY;
                    end else begin
                        wr_idx_next    = cmp_idx_reg;
                        ptr_next       = CNT_W'(cmp_idx_reg) + CNT_W'(1);
                        shift_vld_next = 1'b0;
                        state_next     = ST_SHIFT;
                    end
                end else if (ptr_reg != '0) begin
                    mem_raddr    = ptr_dec[IDX_W-1:0];
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = ptr_dec[IDX_W-1:0];
                    ptr_next     = ptr_dec;
                end else begin
                    cmp_vld_next    = 1'b0;
                    res_status_next = STATUS_MISS;
                    res_ifc_next    = '0;
                    res_cache_next  = 1'b0;
                    state_next      = ST_REPLY;
                end
            end

            ST_SHIFT: begin
                // Entry j+1 is read while entry j, read the cycle before, is
                // written back one place lower, so reads always run ahead of
                // writes.
                if (shift_vld_reg) begin
                    mem_we      = 1'b1;
                    mem_waddr   = wr_idx_reg;
                    mem_wdata   = mem_rdata;
                    wr_idx_next = wr_idx_reg + IDX_W'(1);
                end
                if (ptr_reg < count_reg) begin
                    mem_raddr      = ptr_reg[IDX_W-1:0];
                    shift_vld_next = 1'b1;
                    ptr_next       = ptr_reg + CNT_W'(1);
                end else begin
                    shift_vld_next = 1'b0;
                    count_next     = count_reg - CNT_W'(1);
                    if (cache_hit) begin
                        cache_valid_next = 1'b0;
                        cache_addr_next  = '0;
                        cache_ifc_next   = '0;
                    end
                    res_status_next = STATUS_OK;
                    res_ifc_next    = '0;
                    res_cache_next  = 1'b0;
                    state_next      = ST_REPLY;
                end
            end

            ST_REPLY: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_found_next  = res_ifc_reg;
                    m_cache_next  = res_cache_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
